FILE: rtl/sparse_complex_channel_demod_defines.svh
// assertion macros shared by the demodulator modules
`ifndef SPARSE_COMPLEX_CHANNEL_DEMOD_DEFINES_SVH
`define SPARSE_COMPLEX_CHANNEL_DEMOD_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define SCD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define SCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/scd_pkg.sv
// types, constants and helper functions of the sparse complex channel demodulator
`timescale 1ns / 1ps

package scd_pkg;

   localparam int TAP_COUNT_W = 6;
   localparam logic [15:0] SAT_MAX = 16'h7FFF;
   localparam logic [15:0] SAT_MIN = 16'h8000;

   // command codes of an input word
   typedef enum logic [1:0] {
      FUNC_WR_COEF   = 2'd0,
      FUNC_WR_OFFSET = 2'd1,
      FUNC_WR_SAMPLE = 2'd2,
      FUNC_COMPUTE   = 2'd3
   } scd_func_type;

   typedef struct packed {
      scd_func_type func;
      logic [9:0]   index;
      logic [15:0]  value_i;
      logic [15:0]  value_q;
      logic [9:0]   tap_offset;
   } scd_req_type;

   typedef struct packed {
      logic [15:0] out_i;
      logic [15:0] out_q;
   } scd_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } scd_state_type;

   // controller to datapath
   typedef struct packed {
      logic wr_coef;
      logic wr_offset;
      logic wr_sample;
      logic start;
      logic tap_rd;
      logic out_load;
   } scd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic busy;
   } scd_status_type;

   // saturate a 17-bit sum to 16 bits
   function automatic logic [15:0] scd_sat(input logic [16:0] v);
      if (v[16] != v[15]) begin
         return v[16] ? SAT_MIN : SAT_MAX;
      end
      return v[15:0];
   endfunction

   // remainder of a 12-bit value by a constant of at least 16, reciprocal multiply
   // m is the rounded-up reciprocal scaled by 2**sh
   function automatic logic [16:0] scd_mod(input logic [11:0] x, input logic [16:0] d,
                                           input logic [13:0] m, input int sh);
      logic [25:0] prod;
      logic [11:0] q;
      logic [28:0] qd;
      logic [11:0] r;
      prod = 26'(x) * 26'(m);
      q    = 12'(prod >> sh);
      qd   = 29'(q) * 29'(d);
      r    = x - qd[11:0];
      return 17'(r);
   endfunction

endpackage

FILE: rtl/sparse_complex_channel_demod.sv
// top level of the sparse complex channel demodulator
`timescale 1ns / 1ps

// One 16-bit lane of a sparse complex correlator. Input words write a
// coefficient pair or a tap offset into a tap slot, write an I/Q sample, or
// ask for one output symbol; only a compute word returns a result word.
// Write words are taken one per cycle while no compute is in progress. A
// compute word keeps the input stalled until its result is loaded (with no
// taps the tap walk is skipped): one complex multiply-accumulate per tap
// and cycle walks the tap memories, and the tap memory read, the sample
// memory read, the product register and the accumulator drain before the
// result is loaded. The result goes to an output register, so further
// words are taken while it waits; a following compute finishes only once
// that register is free. The user writes tap_count on the csr port only
// while the block is idle; the block itself does not enforce this. Memory
// contents are undefined until written.
module sparse_complex_channel_demod
   import scd_pkg::*;
#(
   parameter int SAMPLE_DEPTH = 1024,
   parameter int MAX_TAPS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  scd_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output scd_rsp_type            rsp_data,
   input  logic                   csr_wr_en,
   input  logic [TAP_COUNT_W-1:0] csr_wr_data
);

   localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   scd_cmd_type      cmd;
   scd_status_type   status;
   logic [TAP_W-1:0] tap_idx;

   // controller
   scd_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_func    (req_data.func),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd),
      .tap_idx     (tap_idx)
   );

   // datapath
   scd_dp #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .MAX_TAPS(MAX_TAPS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .tap_idx  (tap_idx),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/scd_ram.sv
// generic single write port, single registered read port RAM
`timescale 1ns / 1ps

module scd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/scd_ctrl.sv
// controller: command decode, tap sequencing and result word handshake
`timescale 1ns / 1ps
`include "sparse_complex_channel_demod_defines.svh"

module scd_ctrl
   import scd_pkg::*;
#(
   parameter int MAX_TAPS = 32,
   localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  scd_func_type           req_func,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   csr_wr_en,
   input  logic [TAP_COUNT_W-1:0] csr_wr_data,
   input  scd_status_type         status,
   output scd_cmd_type            cmd,
   output logic [TAP_W-1:0]       tap_idx
);

   localparam int CNT_W = $clog2(MAX_TAPS + 1);
   localparam logic [8:0] MAX_TAPS_L = 9'(MAX_TAPS);

   scd_state_type state_ff, state_in;
   logic [TAP_COUNT_W-1:0] tap_count_ff, tap_count_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic slot_free;
   logic last_tap;
   logic [8:0] tap_count_l;
   logic [CNT_W-1:0] n_clip;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_tap  = (cnt_ff + CNT_W'(1)) == n_ff;

   // tap count clipped to the tap memory depth
   assign tap_count_l = 9'(tap_count_ff);
   assign n_clip = (tap_count_l > MAX_TAPS_L) ? CNT_W'(MAX_TAPS_L) : CNT_W'(tap_count_l);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_COMPUTE) begin
               state_in = (n_clip == '0) ? ST_DRAIN : ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      tap_idx   = cnt_ff[TAP_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               unique case (req_func)
                  FUNC_WR_COEF:   cmd.wr_coef   = 1'b1;
                  FUNC_WR_OFFSET: cmd.wr_offset = 1'b1;
                  FUNC_WR_SAMPLE: cmd.wr_sample = 1'b1;
                  FUNC_COMPUTE:   cmd.start     = 1'b1;
                  default:        cmd           = '0;
               endcase
            end
         end
         ST_RUN:    cmd.tap_rd   = 1'b1;
         ST_DRAIN:  cmd          = '0;
         ST_FINISH: cmd.out_load = slot_free;
         default:   cmd          = '0;
      endcase
   end

   // counters, tap count register and result valid
   always_comb begin
      tap_count_in = csr_wr_en ? csr_wr_data : tap_count_ff;
      cnt_in = cnt_ff;
      n_in   = n_ff;
      if (cmd.start) begin
         cnt_in = '0;
         n_in   = n_clip;
      end else if (cmd.tap_rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_count_ff <= '0;
         cnt_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_count_ff <= tap_count_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `SCD_ASSERT_NOW(a_tap_in_range, clock, reset, cmd.tap_rd, cnt_ff < n_ff,
      "tap read beyond the tap count")
   `SCD_ASSERT_NOW(a_load_slot_free, clock, reset, cmd.out_load,
      (!rsp_valid_ff || !rsp_stall), "result overwritten while still held")
   `SCD_ASSERT_NEXT(a_start_leaves_idle, clock, reset, cmd.start,
      (state_ff == ST_RUN || state_ff == ST_DRAIN), "compute did not start")

endmodule

FILE: rtl/scd_dp.sv
// datapath: tap, offset and sample memories, address reduction and complex MAC
`timescale 1ns / 1ps
`include "sparse_complex_channel_demod_defines.svh"

module scd_dp
   import scd_pkg::*;
#(
   parameter int SAMPLE_DEPTH = 1024,
   parameter int MAX_TAPS = 32,
   localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  scd_req_type      req_data,
   input  scd_cmd_type      cmd,
   input  logic [TAP_W-1:0] tap_idx,
   output scd_status_type   status,
   output scd_rsp_type      rsp_data
);

   localparam int SA_W = $clog2(SAMPLE_DEPTH);
   localparam logic [16:0] DEPTH_17 = 17'(SAMPLE_DEPTH);
   localparam logic [SA_W:0] DEPTH_L = (SA_W + 1)'(SAMPLE_DEPTH);
   localparam logic [10:0] MAX_TAPS_L = 11'(MAX_TAPS);
   localparam int RECIP_SH = 12 + SA_W;
   localparam logic [13:0] RECIP =
      14'(((64'd1 << RECIP_SH) + 64'(SAMPLE_DEPTH) - 64'd1) / 64'(SAMPLE_DEPTH));

   logic slot_ok;
   logic [16:0] wr_samp_mod, wr_off_mod, base_mod;
   logic [SA_W-1:0] base_ff, base_in;
   logic [SA_W-1:0] off_rd;
   logic [31:0] coef_rd;
   logic [31:0] samp_rd;
   logic [SA_W:0] addr_sum, addr_sub;
   logic [SA_W-1:0] samp_rd_addr;
   logic v1_ff, v2_ff, v3_ff;
   logic [31:0] coef_d_ff;
   logic [15:0] p_ii_ff, p_qq_ff, p_iq_ff, p_qi_ff;
   logic [15:0] p_ii_in, p_qq_in, p_iq_in, p_qi_in;
   logic [15:0] acc_i_ff, acc_q_ff, acc_i_in, acc_q_in;
   logic [15:0] acc_i_mid, acc_q_mid;
   scd_rsp_type rsp_ff, rsp_in;

   // address reduction for writes and symbol base
   assign slot_ok     = {1'b0, req_data.index} < MAX_TAPS_L;
   assign wr_samp_mod = scd_mod({2'b00, req_data.index}, DEPTH_17, RECIP, RECIP_SH);
   assign wr_off_mod  = scd_mod({2'b00, req_data.tap_offset}, DEPTH_17, RECIP, RECIP_SH);
   assign base_mod    = scd_mod({1'b0, req_data.index, 1'b0}, DEPTH_17, RECIP, RECIP_SH);
   assign base_in     = cmd.start ? base_mod[SA_W-1:0] : base_ff;

   // coefficient pairs, one per tap slot
   scd_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_coef && slot_ok),
      .wr_addr (req_data.index[TAP_W-1:0]),
      .wr_data ({req_data.value_i, req_data.value_q}),
      .rd_addr (tap_idx),
      .rd_data (coef_rd)
   );

   // tap offsets, stored already reduced by the sample depth
   scd_ram #(.WIDTH(SA_W), .DEPTH(MAX_TAPS)) u_offset_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_offset && slot_ok),
      .wr_addr (req_data.index[TAP_W-1:0]),
      .wr_data (wr_off_mod[SA_W-1:0]),
      .rd_addr (tap_idx),
      .rd_data (off_rd)
   );

   // sample address of the tap, wrapped once
   assign addr_sum     = {1'b0, base_ff} + {1'b0, off_rd};
   assign addr_sub     = addr_sum - DEPTH_L;
   assign samp_rd_addr = (addr_sum >= DEPTH_L) ? addr_sub[SA_W-1:0] : addr_sum[SA_W-1:0];

   // I/Q sample memory
   scd_ram #(.WIDTH(32), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_sample),
      .wr_addr (wr_samp_mod[SA_W-1:0]),
      .wr_data ({req_data.value_i, req_data.value_q}),
      .rd_addr (samp_rd_addr),
      .rd_data (samp_rd)
   );

   // low halves of the four partial products
   assign p_ii_in = samp_rd[31:16] * coef_d_ff[31:16];
   assign p_qq_in = samp_rd[15:0]  * coef_d_ff[15:0];
   assign p_iq_in = samp_rd[31:16] * coef_d_ff[15:0];
   assign p_qi_in = samp_rd[15:0]  * coef_d_ff[31:16];

   // saturating accumulation in two steps per component
   always_comb begin
      acc_i_mid = scd_sat({acc_i_ff[15], acc_i_ff} + {p_ii_ff[15], p_ii_ff});
      acc_q_mid = scd_sat({acc_q_ff[15], acc_q_ff} - {p_iq_ff[15], p_iq_ff});
      acc_i_in  = acc_i_ff;
      acc_q_in  = acc_q_ff;
      if (cmd.start) begin
         acc_i_in = '0;
         acc_q_in = '0;
      end else if (v3_ff) begin
         acc_i_in = scd_sat({acc_i_mid[15], acc_i_mid} + {p_qq_ff[15], p_qq_ff});
         acc_q_in = scd_sat({acc_q_mid[15], acc_q_mid} + {p_qi_ff[15], p_qi_ff});
      end
   end

   // result word register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in.out_i = acc_i_ff;
         rsp_in.out_q = acc_q_ff;
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.tap_rd;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      coef_d_ff <= coef_rd;
      p_ii_ff   <= p_ii_in;
      p_qq_ff   <= p_qq_in;
      p_iq_ff   <= p_iq_in;
      p_qi_ff   <= p_qi_in;
      acc_i_ff  <= acc_i_in;
      acc_q_ff  <= acc_q_in;
      rsp_ff    <= rsp_in;
   end

   assign status.busy = v1_ff || v2_ff || v3_ff;
   assign rsp_data    = rsp_ff;

   // checks
   `SCD_ASSERT_NOW(a_addr_wrapped, clock, reset, v1_ff, {1'b0, samp_rd_addr} < DEPTH_L,
      "sample address not reduced")
   `SCD_ASSERT_NOW(a_load_after_drain, clock, reset, cmd.out_load, !status.busy,
      "result loaded with taps in flight")

endmodule

FILE: test/demod_checker.sv
// result checker for the sparse complex channel demodulator: prediction and comparison
`timescale 1ns / 1ps

module demod_checker
   import scd_pkg::*;
#(
   parameter int SAMPLE_DEPTH = 1024,
   parameter int MAX_TAPS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  scd_req_type            req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  scd_rsp_type            rsp_data,
   input  logic                   csr_wr_en,
   input  logic [TAP_COUNT_W-1:0] csr_wr_data,
   output int                     mismatch_count,
   output int                     pending_count
);

   // shadow of the block's memories and tap count
   logic [15:0]            samp_i [SAMPLE_DEPTH];
   logic [15:0]            samp_q [SAMPLE_DEPTH];
   logic [15:0]            coef_i [MAX_TAPS];
   logic [15:0]            coef_q [MAX_TAPS];
   logic [9:0]             tap_off [MAX_TAPS];
   logic [TAP_COUNT_W-1:0] taps_in_use;

   // symbols still owed by the block, oldest first
   scd_rsp_type pending_symbols[$];

   initial begin
      mismatch_count = 0;
      pending_count = 0;
      taps_in_use = '0;
   end

   // low half of an unsigned 16x16 product, read as signed
   function automatic int lo_product(input logic [15:0] a, input logic [15:0] b);
      logic [31:0]        p;
      logic signed [15:0] lo;
      p = a * b;
      lo = p[15:0];
      return lo;
   endfunction

   function automatic int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // conjugate multiply-accumulate over the active taps for one symbol
   function automatic scd_rsp_type correlate_symbol(input logic [9:0] sym);
      int          n;
      int          addr;
      int          acc_i;
      int          acc_q;
      scd_rsp_type r;
      n = (int'(taps_in_use) > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
      acc_i = 0;
      acc_q = 0;
      for (int j = 0; j < n; j++) begin
         addr = (2 * int'(sym) + int'(tap_off[j])) % SAMPLE_DEPTH;
         acc_i = clamp16(acc_i + lo_product(samp_i[addr], coef_i[j]));
         acc_i = clamp16(acc_i + lo_product(samp_q[addr], coef_q[j]));
         acc_q = clamp16(acc_q - lo_product(samp_i[addr], coef_q[j]));
         acc_q = clamp16(acc_q + lo_product(samp_q[addr], coef_i[j]));
      end
      r.out_i = acc_i[15:0];
      r.out_q = acc_q[15:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int want_v, input int got_v);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("demod_checker: %s mismatch at %0t, expected %0d got %0d",
                  what, $realtime, want_v, got_v);
      end
   endtask

   // watch both channels and the csr port at every rising edge
   always @(posedge clock) begin
      scd_rsp_type want;
      if (reset) begin
         taps_in_use = '0;
         pending_symbols.delete();
      end else begin
         // result word against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (pending_symbols.size() == 0) begin
               report_mismatch("unexpected result word, out_i", 0,
                               int'($signed(rsp_data.out_i)));
            end else begin
               want = pending_symbols.pop_front();
               if (rsp_data.out_i !== want.out_i) begin
                  report_mismatch("out_i", int'($signed(want.out_i)),
                                  int'($signed(rsp_data.out_i)));
               end
               if (rsp_data.out_q !== want.out_q) begin
                  report_mismatch("out_q", int'($signed(want.out_q)),
                                  int'($signed(rsp_data.out_q)));
               end
            end
         end
         if (csr_wr_en) begin
            taps_in_use = csr_wr_data;
         end
         // accepted command word
         if (req_valid && !req_stall) begin
            case (req_data.func)
               FUNC_WR_COEF: begin
                  if (req_data.index < MAX_TAPS) begin
                     coef_i[req_data.index] = req_data.value_i;
                     coef_q[req_data.index] = req_data.value_q;
                  end
               end
               FUNC_WR_OFFSET: begin
                  if (req_data.index < MAX_TAPS) begin
                     tap_off[req_data.index] = req_data.tap_offset;
                  end
               end
               FUNC_WR_SAMPLE: begin
                  samp_i[int'(req_data.index) % SAMPLE_DEPTH] = req_data.value_i;
                  samp_q[int'(req_data.index) % SAMPLE_DEPTH] = req_data.value_q;
               end
               default: begin
                  pending_symbols.push_back(correlate_symbol(req_data.index));
               end
            endcase
         end
      end
      pending_count = pending_symbols.size();
   end

endmodule

FILE: test/testbench.sv
// top of the demodulator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
   import scd_pkg::*;

   localparam int SAMPLE_DEPTH = 1024;
   localparam int MAX_TAPS = 32;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   scd_req_type            req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   scd_rsp_type            rsp_data;
   logic                   csr_wr_en;
   logic [TAP_COUNT_W-1:0] csr_wr_data;
   int                     mismatch_count;
   int                     pending_count;

   // stimulus bookkeeping: which entries hold data, so no compute reads an unwritten one
   bit          coef_set [MAX_TAPS];
   bit          off_set [MAX_TAPS];
   bit          samp_set [SAMPLE_DEPTH];
   logic [9:0]  off_shadow [MAX_TAPS];
   int          taps_now;
   int          words_sent;
   logic        calm;

   sparse_complex_channel_demod #(
      .SAMPLE_DEPTH(SAMPLE_DEPTH),
      .MAX_TAPS(MAX_TAPS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   demod_checker #(
      .SAMPLE_DEPTH(SAMPLE_DEPTH),
      .MAX_TAPS(MAX_TAPS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, some short, a few long; none while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // full-range values with the extremes favoured
   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // tap slot, often out of range so the write is dropped
   function automatic int slot_pick();
      if ($urandom_range(0, 3) != 0) return $urandom_range(0, MAX_TAPS - 1);
      return $urandom_range(0, 1023);
   endfunction

   function automatic scd_req_type rand_word();
      scd_req_type w;
      w.func = scd_func_type'($urandom_range(0, 3));
      w.index = 10'($urandom);
      w.value_i = rand_value();
      w.value_q = rand_value();
      w.tap_offset = 10'($urandom);
      return w;
   endfunction

   // result side stalls
   initial begin
      int len;
      rsp_stall = 1'b0;
      forever begin
         len = pick_gap();
         @(negedge clock);
         if (len == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            repeat (len - 1) @(negedge clock);
         end
      end
   end

   // present one word and hold it until taken
   task automatic send_word(input scd_req_type w);
      int gap;
      gap = pick_gap();
      if ($urandom_range(0, 63) == 0) calm = !calm;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!((w.func == FUNC_WR_COEF || w.func == FUNC_WR_OFFSET) && w.index >= MAX_TAPS)) begin
         words_sent++;
      end
   endtask

   task automatic put_coef(input int slot, input logic [15:0] vi, input logic [15:0] vq);
      scd_req_type w;
      w = rand_word();
      w.func = FUNC_WR_COEF;
      w.index = 10'(slot);
      w.value_i = vi;
      w.value_q = vq;
      send_word(w);
      if (slot < MAX_TAPS) coef_set[slot] = 1'b1;
   endtask

   task automatic put_offset(input int slot, input logic [9:0] off);
      scd_req_type w;
      w = rand_word();
      w.func = FUNC_WR_OFFSET;
      w.index = 10'(slot);
      w.tap_offset = off;
      send_word(w);
      if (slot < MAX_TAPS) begin
         off_set[slot] = 1'b1;
         off_shadow[slot] = off;
      end
   endtask

   task automatic put_sample(input int addr, input logic [15:0] vi, input logic [15:0] vq);
      scd_req_type w;
      w = rand_word();
      w.func = FUNC_WR_SAMPLE;
      w.index = 10'(addr);
      w.value_i = vi;
      w.value_q = vq;
      send_word(w);
      samp_set[addr % SAMPLE_DEPTH] = 1'b1;
   endtask

   // fill whatever the symbol would read unwritten, then ask for it
   task automatic ask_symbol(input logic [9:0] sym);
      int          n;
      int          addr;
      scd_req_type w;
      n = (taps_now > MAX_TAPS) ? MAX_TAPS : taps_now;
      for (int j = 0; j < n; j++) begin
         if (!coef_set[j]) put_coef(j, rand_value(), rand_value());
         if (!off_set[j]) put_offset(j, 10'($urandom));
         addr = (2 * int'(sym) + int'(off_shadow[j])) % SAMPLE_DEPTH;
         if (!samp_set[addr]) put_sample(addr, rand_value(), rand_value());
      end
      w = rand_word();
      w.func = FUNC_COMPUTE;
      w.index = sym;
      send_word(w);
   endtask

   // tap count change once the block has drained
   task automatic set_tap_count(input int v);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= TAP_COUNT_W'(v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      taps_now = v;
   endtask

   // run limit
   initial begin
      #10_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      int tap_plan [6];
      int target;
      int r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      taps_now = 0;
      words_sent = 0;
      calm = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // zero taps, dropped slot writes
      set_tap_count(0);
      ask_symbol(10'd0);
      ask_symbol(10'd1023);
      put_coef(MAX_TAPS, 16'h7FFF, 16'h8000);
      put_offset(1023, 10'h3FF);

      // two taps at the extremes of value and offset
      set_tap_count(2);
      put_coef(0, 16'h8000, 16'h8000);
      put_coef(1, 16'h7FFF, 16'h7FFF);
      put_offset(0, 10'd0);
      put_offset(1, 10'h3FF);
      put_sample(1022, 16'h8000, 16'h7FFF);
      put_sample(1021, 16'h7FFF, 16'h8000);
      ask_symbol(10'd1023);
      put_sample(0, 16'h0000, 16'h0000);
      put_sample(1023, 16'hFFFF, 16'hFFFF);
      ask_symbol(10'd0);
      put_coef(0, 16'h0000, 16'hFFFF);
      ask_symbol(10'd0);

      // random phases, tap count beyond the slot count included
      tap_plan = '{32, 63, 1, 33, 0, 0};
      tap_plan[5] = $urandom_range(3, 31);
      foreach (tap_plan[p]) begin
         set_tap_count(tap_plan[p]);
         target = words_sent + 200;
         while (words_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               ask_symbol(10'($urandom));
            end else if (r < 72) begin
               put_coef(slot_pick(), rand_value(), rand_value());
            end else if (r < 84) begin
               put_offset(slot_pick(), 10'($urandom));
            end else begin
               put_sample($urandom_range(0, SAMPLE_DEPTH - 1), rand_value(), rand_value());
            end
         end
      end

      // drain and settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/scd_pkg.sv
rtl/scd_ram.sv
rtl/scd_ctrl.sv
rtl/scd_dp.sv
rtl/sparse_complex_channel_demod.sv
test/demod_checker.sv
test/testbench.sv
